FILE: src/sppi_pkg.sv
// shared types and constants for the spectrum peak interpolator
package sppi_pkg;

    localparam int MAG_PORT_W = 32;
    localparam int FS_W       = 20;
    localparam int FREQ_W     = 27;
    localparam int BIN_W      = 10;
    localparam int FRAC_W     = 24;

    localparam logic [FS_W-1:0] FS_RESET = 20'd10000;

    typedef struct packed {
        logic [MAG_PORT_W-1:0] magnitude;
        logic                  last_bin;
    } in_item_t;

    typedef struct packed {
        logic [FREQ_W-1:0] peak_freq;
        logic              peak_found;
        logic [BIN_W-1:0]  peak_bin;
    } out_item_t;

endpackage

FILE: src/spectrum_peak_parabolic_interp_top.sv
// spectrum peak finder with parabolic interpolation, top level
// bins are taken one per cycle while s_ready is high; with no peak the item goes straight to S_DONE
// with a peak it first passes set-up (S_P, S_Q, S_DEN), a restoring fraction division, the position and
// a shift-add multiply by the sample rate on one shared adder; N*2^16 (N a power of two) is a shift
// s_ready is low from the last bin until the item enters the output register, once that is free
// reset clears the window, the peak and the result valid, and sets the sample rate to 10000 Hz
module spectrum_peak_parabolic_interp_top #(
    parameter int FFT_POINTS = 1024,
    parameter int MAG_WIDTH  = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  sppi_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output sppi_pkg::out_item_t          m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sppi_pkg::FS_W-1:0]    cfg_data
);

    localparam int HALF  = FFT_POINTS / 2;
    localparam int MW    = (MAG_WIDTH < sppi_pkg::MAG_PORT_W) ? MAG_WIDTH : sppi_pkg::MAG_PORT_W;
    localparam int IW    = $clog2(HALF + 1);
    localparam int CW    = $clog2(HALF + 3);
    localparam int PW    = IW + sppi_pkg::FRAC_W;
    localparam int PRW   = PW + sppi_pkg::FS_W;
    localparam int DW    = $clog2(FFT_POINTS) + 17;
    localparam int AW0   = (PRW > DW + 1) ? PRW : DW + 1;
    localparam int AW    = (AW0 > MW + 2) ? AW0 : MW + 2;
    localparam int CNTW  = $clog2(PRW + 1);
    localparam int FSH   = $clog2(FFT_POINTS) + 16;

    localparam logic [AW-1:0] HALF_BIN = AW'(64'(1) << (sppi_pkg::FRAC_W - 1));

    typedef enum logic [3:0] {
        S_RUN, S_P, S_Q, S_DEN, S_FRAC, S_POS, S_MUL, S_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [sppi_pkg::FS_W-1:0]  fs_reg, fs_next;
    logic [MW-1:0]              older_reg, older_next;
    logic [MW-1:0]              prior_reg, prior_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [MW-1:0]              best_mag_reg, best_mag_next;
    logic [IW-1:0]              best_idx_reg, best_idx_next;
    logic [MW-1:0]              best_left_reg, best_left_next;
    logic [MW-1:0]              best_right_reg, best_right_next;
    logic [MW-1:0]              wk_mag_reg, wk_mag_next;
    logic [MW-1:0]              wk_left_reg, wk_left_next;
    logic [MW-1:0]              wk_right_reg, wk_right_next;
    logic [IW-1:0]              wk_idx_reg, wk_idx_next;
    logic [MW-1:0]              p_reg, p_next;
    logic [MW:0]                den_reg, den_next;
    logic [AW-1:0]              acc_reg, acc_next;
    logic [PRW-1:0]             opnd_reg, opnd_next;
    logic [sppi_pkg::FRAC_W-1:0] quo_reg, quo_next;
    logic [sppi_pkg::FS_W-1:0]  fs_sh_reg, fs_sh_next;
    logic [CNTW-1:0]            cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    sppi_pkg::out_item_t        out_reg, out_next;

    logic [AW-1:0]  alu_a, alu_b;
    logic           alu_sub;
    logic [AW:0]    alu_sum;
    logic           alu_carry;
    logic [AW-1:0]  alu_res;

    logic [MW-1:0]  mag;
    logic           take;
    logic           is_peak;
    logic [AW-1:0]  rem_shift;
    logic [31:0]    idx_wide;
    logic [PRW-1:0] prod_shift;

    assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {{AW{1'b0}}, alu_sub};
    assign alu_carry = alu_sum[AW];
    assign alu_res   = alu_sum[AW-1:0];

    assign s_ready   = (state_reg == S_RUN);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    assign mag        = s_data.magnitude[MW-1:0];
    assign take       = s_valid && s_ready;
    assign idx_wide   = 32'(wk_idx_reg);
    assign prod_shift = opnd_reg >> FSH;

    // strict local maximum test on the centre bin, which must also exceed the kept peak
    assign is_peak = (count_reg >= CW'(2)) && (older_reg < prior_reg) && (prior_reg > mag)
                     && (prior_reg > best_mag_reg);

    always_comb begin
        state_next      = state_reg;
        fs_next         = cfg_valid ? cfg_data : fs_reg;
        older_next      = older_reg;
        prior_next      = prior_reg;
        count_next      = count_reg;
        best_mag_next   = best_mag_reg;
        best_idx_next   = best_idx_reg;
        best_left_next  = best_left_reg;
        best_right_next = best_right_reg;
        wk_mag_next     = wk_mag_reg;
        wk_left_next    = wk_left_reg;
        wk_right_next   = wk_right_reg;
        wk_idx_next     = wk_idx_reg;
        p_next          = p_reg;
        den_next        = den_reg;
        acc_next        = acc_reg;
        opnd_next       = opnd_reg;
        quo_next        = quo_reg;
        fs_sh_next      = fs_sh_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = (out_valid_reg && m_ready) ? 1'b0 : out_valid_reg;
        out_next        = out_reg;
        alu_a           = '0;
        alu_b           = '0;
        alu_sub         = 1'b0;
        rem_shift       = '0;

        case (state_reg)
            S_RUN: begin
                if (take) begin
                    if (count_reg <= CW'(HALF + 1)) begin
                        if (is_peak) begin
                            best_mag_next   = prior_reg;
                            best_idx_next   = IW'(count_reg - CW'(1));
                            best_left_next  = older_reg;
                            best_right_next = mag;
                        end
                        older_next = prior_reg;
                        prior_next = mag;
                        count_next = count_reg + CW'(1);
                    end
                    if (s_data.last_bin) begin
                        wk_mag_next     = best_mag_next;
                        wk_idx_next     = best_idx_next;
                        wk_left_next    = best_left_next;
                        wk_right_next   = best_right_next;
                        older_next      = '0;
                        prior_next      = '0;
                        count_next      = '0;
                        best_mag_next   = '0;
                        best_idx_next   = '0;
                        best_left_next  = '0;
                        best_right_next = '0;
                        opnd_next       = '0;
                        state_next      = (wk_idx_next == '0) ? S_DONE : S_P;
                    end
                end
            end
            S_P: begin
                alu_a      = AW'(wk_mag_reg);
                alu_b      = AW'(wk_left_reg);
                alu_sub    = 1'b1;
                p_next     = alu_res[MW-1:0];
                state_next = S_Q;
            end
            S_Q: begin
                alu_a      = AW'(wk_mag_reg);
                alu_b      = AW'(wk_right_reg);
                alu_sub    = 1'b1;
                den_next   = {1'b0, alu_res[MW-1:0]};
                state_next = S_DEN;
            end
            S_DEN: begin
                alu_a      = AW'(p_reg);
                alu_b      = AW'(den_reg);
                den_next   = alu_res[MW:0];
                acc_next   = AW'(p_reg);
                cnt_next   = CNTW'(sppi_pkg::FRAC_W);
                state_next = S_FRAC;
            end
            S_FRAC: begin
                rem_shift = {acc_reg[AW-2:0], 1'b0};
                alu_a     = rem_shift;
                alu_b     = AW'(den_reg);
                alu_sub   = 1'b1;
                acc_next  = alu_carry ? alu_res : rem_shift;
                quo_next  = {quo_reg[sppi_pkg::FRAC_W-2:0], alu_carry};
                cnt_next  = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) begin
                    state_next = S_POS;
                end
            end
            S_POS: begin
                // index and fraction side by side, less half a bin
                alu_a      = AW'({wk_idx_reg, quo_reg[sppi_pkg::FRAC_W-1:0]});
                alu_b      = HALF_BIN;
                alu_sub    = 1'b1;
                opnd_next  = alu_res[PRW-1:0];
                acc_next   = '0;
                fs_sh_next = fs_reg;
                cnt_next   = CNTW'(sppi_pkg::FS_W);
                state_next = S_MUL;
            end
            S_MUL: begin
                alu_a      = {acc_reg[AW-2:0], 1'b0};
                alu_b      = fs_sh_reg[sppi_pkg::FS_W-1] ? AW'(opnd_reg) : '0;
                acc_next   = alu_res;
                fs_sh_next = {fs_sh_reg[sppi_pkg::FS_W-2:0], 1'b0};
                cnt_next   = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) begin
                    opnd_next  = alu_res[PRW-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_next.peak_freq  = (|prod_shift[PRW-1:sppi_pkg::FREQ_W])
                                          ? {sppi_pkg::FREQ_W{1'b1}}
                                          : prod_shift[sppi_pkg::FREQ_W-1:0];
                    out_next.peak_found = (wk_idx_reg != '0);
                    out_next.peak_bin   = idx_wide[sppi_pkg::BIN_W-1:0];
                    out_valid_next      = 1'b1;
                    state_next          = S_RUN;
                end
            end
            default: begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_RUN;
            fs_reg         <= sppi_pkg::FS_RESET;
            older_reg      <= '0;
            prior_reg      <= '0;
            count_reg      <= '0;
            best_mag_reg   <= '0;
            best_idx_reg   <= '0;
            best_left_reg  <= '0;
            best_right_reg <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fs_reg         <= fs_next;
            older_reg      <= older_next;
            prior_reg      <= prior_next;
            count_reg      <= count_next;
            best_mag_reg   <= best_mag_next;
            best_idx_reg   <= best_idx_next;
            best_left_reg  <= best_left_next;
            best_right_reg <= best_right_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
        wk_mag_reg   <= wk_mag_next;
        wk_left_reg  <= wk_left_next;
        wk_right_reg <= wk_right_next;
        wk_idx_reg   <= wk_idx_next;
        p_reg        <= p_next;
        den_reg      <= den_next;
        acc_reg      <= acc_next;
        opnd_reg     <= opnd_next;
        quo_reg      <= quo_next;
        fs_sh_reg    <= fs_sh_next;
        out_reg      <= out_next;
    end

    // the last bin of a spectrum starts the sequence
    a_last_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.last_bin) |=> !s_ready)
        else $error("input still taken after last bin");

    a_no_peak_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.peak_found) |-> (m_data.peak_freq == '0 && m_data.peak_bin == '0))
        else $error("no-peak item carries nonzero fields");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(HALF + 2))
        else $error("bin count beyond window range");

    a_peak_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (best_idx_reg != '0) |-> (best_mag_reg > best_left_reg && best_mag_reg > best_right_reg))
        else $error("kept peak not a strict maximum");

endmodule
